>>> rtl/sxfr_pkg.sv
// ----------------------------------------------------------------------------
// sxfr_pkg
// Shared types and constants of the sync/XOR frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sxfr_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned BODY_LEN   = 14;   // body bytes before the checksum
   localparam int unsigned COUNT_W    = 4;
   localparam int unsigned CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_SECOND = 2'd1;

   localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;

   localparam logic [COUNT_W-1:0] CHECKSUM_POS = 4'(BODY_LEN);

   // control word from the framer to the body chain and output stage
   typedef struct packed {
      logic               in_body;
      logic               last;    // next body word is the checksum
      logic               shift;   // push the accepted word into the chain
      logic               fire;    // checksum word accepted, result ready
      logic               ok;      // checksum matched
      logic [COUNT_W-1:0] count;
   } ctrl_type;

endpackage

`default_nettype wire

>>> rtl/sxfr_cell.sv
// ----------------------------------------------------------------------------
// sxfr_cell
// One byte cell of the body chain; loads from its neighbour on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module sxfr_cell (
   input  wire logic                         clock,
   input  wire logic                         shift_en,
   input  wire logic [sxfr_pkg::BYTE_W-1:0]  d_in,
   output logic      [sxfr_pkg::BYTE_W-1:0]  q
);

   logic [sxfr_pkg::BYTE_W-1:0] data_ff;
   logic [sxfr_pkg::BYTE_W-1:0] data_in;

   assign data_in = shift_en ? d_in : data_ff;

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign q = data_ff;

endmodule

`default_nettype wire

>>> rtl/sxfr_ctrl.sv
// ----------------------------------------------------------------------------
// sxfr_ctrl
// Sync hunt, body counter and running XOR checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module sxfr_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire logic [sxfr_pkg::BYTE_W-1:0]  data_byte,
   input  wire logic [sxfr_pkg::BYTE_W-1:0]  sync_first,
   input  wire logic [sxfr_pkg::BYTE_W-1:0]  sync_second,
   output sxfr_pkg::ctrl_type                ctl
);

   logic                          in_body_ff, in_body_in;
   logic [sxfr_pkg::BYTE_W-1:0]   prev_ff, prev_in;
   logic [sxfr_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [sxfr_pkg::BYTE_W-1:0]   xor_ff, xor_in;
   logic                          last;
   logic                          sync_hit;

   assign last     = in_body_ff && (count_ff == sxfr_pkg::CHECKSUM_POS);
   assign sync_hit = (prev_ff == sync_first) && (data_byte == sync_second);

   always_comb begin
      in_body_in = in_body_ff;
      prev_in    = prev_ff;
      count_in   = count_ff;
      xor_in     = xor_ff;
      if (accept) begin
         if (!in_body_ff) begin
            // sync byte itself never becomes the previous byte
            if (sync_hit) begin
               in_body_in = 1'b1;
               count_in   = '0;
               xor_in     = '0;
            end else begin
               prev_in = data_byte;
            end
         end else if (!last) begin
            xor_in   = xor_ff ^ data_byte;
            count_in = count_ff + 1'b1;
         end else begin
            in_body_in = 1'b0;
            prev_in    = '0;
            count_in   = '0;
            xor_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_body_ff <= 1'b0;
         prev_ff    <= '0;
         count_ff   <= '0;
         xor_ff     <= '0;
      end else begin
         in_body_ff <= in_body_in;
         prev_ff    <= prev_in;
         count_ff   <= count_in;
         xor_ff     <= xor_in;
      end
   end

   assign ctl.in_body = in_body_ff;
   assign ctl.last    = last;
   assign ctl.shift   = accept && in_body_ff && !last;
   assign ctl.fire    = accept && last;
   assign ctl.ok      = (xor_ff == data_byte);
   assign ctl.count   = count_ff;

endmodule

`default_nettype wire

>>> rtl/sync_xor_frame_receiver.sv
// ----------------------------------------------------------------------------
// sync_xor_frame_receiver
// Byte stream framer: sync pair hunt, 14-byte body chain, XOR checksum.
// ----------------------------------------------------------------------------
//  channel   ports                               direction   width
//  req       req_valid req_stall req_data_byte   in          8
//  rsp       rsp_valid rsp_stall rsp_*           out         8/32/48/8/8/8/1
//  csr       csr_valid csr_ready csr_index/wdata in          2 / 8
//
//  one word per unstalled cycle; body words ripple into a chain of 14 cells
//  the result is registered on the cycle the checksum word is accepted
//  req_stall rises only when the checksum word is due while the held result
//  is still stalled; reset is synchronous, clears control, presets sync bytes
// ----------------------------------------------------------------------------
`default_nettype none

module sync_xor_frame_receiver (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [7:0]                       req_data_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [7:0]                            rsp_sequence_res,
   output logic [31:0]                           rsp_slider_data,
   output logic [47:0]                           rsp_air_bytes,
   output logic [7:0]                            rsp_test_button,
   output logic [7:0]                            rsp_service_button,
   output logic [7:0]                            rsp_coin_button,
   output logic                                  rsp_checksum_ok,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [sxfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [7:0]                       csr_wdata
);

   logic [7:0]          sync_first_ff, sync_first_in;
   logic [7:0]          sync_second_ff, sync_second_in;
   logic                accept;
   sxfr_pkg::ctrl_type  ctl;
   logic [7:0]          chain [sxfr_pkg::BODY_LEN+1];

   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          seq_ff;
   logic [31:0]         slider_ff;
   logic [47:0]         air_ff;
   logic [7:0]          test_ff, service_ff, coin_ff;
   logic                ok_ff;

   // configuration
   assign csr_ready = 1'b1;

   always_comb begin
      sync_first_in  = sync_first_ff;
      sync_second_in = sync_second_ff;
      if (csr_valid) begin
         case (csr_index)
            sxfr_pkg::CSR_SYNC_FIRST:  sync_first_in  = csr_wdata;
            sxfr_pkg::CSR_SYNC_SECOND: sync_second_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= sxfr_pkg::SYNC_FIRST_RST;
         sync_second_ff <= sxfr_pkg::SYNC_SECOND_RST;
      end else begin
         sync_first_ff  <= sync_first_in;
         sync_second_ff <= sync_second_in;
      end
   end

   // handshake
   assign req_stall = ctl.last && rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   sxfr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .sync_first  (sync_first_ff),
      .sync_second (sync_second_ff),
      .ctl         (ctl)
   );

   // body chain: new word enters at the top, oldest ends in cell 0
   assign chain[sxfr_pkg::BODY_LEN] = req_data_byte;

   for (genvar i = 0; i < sxfr_pkg::BODY_LEN; i++) begin : g_cell
      sxfr_cell u_cell (
         .clock    (clock),
         .shift_en (ctl.shift),
         .d_in     (chain[i+1]),
         .q        (chain[i])
      );
   end

   // output register
   assign rsp_valid_in = ctl.fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.fire) begin
         seq_ff     <= chain[0];
         slider_ff  <= {chain[4], chain[3], chain[2], chain[1]};
         air_ff     <= {chain[10], chain[9], chain[8], chain[7], chain[6], chain[5]};
         test_ff    <= chain[11];
         service_ff <= chain[12];
         coin_ff    <= chain[13];
         ok_ff      <= ctl.ok;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sequence_res   = seq_ff;
   assign rsp_slider_data    = slider_ff;
   assign rsp_air_bytes      = air_ff;
   assign rsp_test_button    = test_ff;
   assign rsp_service_button = service_ff;
   assign rsp_coin_button    = coin_ff;
   assign rsp_checksum_ok    = ok_ff;

   // checks
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.fire |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      ctl.count <= sxfr_pkg::CHECKSUM_POS)
      else $error("body count out of range");

   a_fire_to_hunt: assert property (@(posedge clock) disable iff (reset)
      ctl.fire |=> (rsp_valid && !ctl.in_body))
      else $error("frame end did not raise result and restart hunt");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_air_bytes)))
      else $error("stalled result changed");

endmodule

`default_nettype wire
